### rtl/gbl_pkg.sv
// shared types, constants and glyph rom for the scaled glyph blitter
package gbl_pkg;

	localparam int GLYPH_W  = 5;
	localparam int GLYPH_H  = 7;
	localparam int ADVANCE  = 6;
	localparam int MASK_W   = GLYPH_W * GLYPH_H;
	localparam int COL_W    = $clog2(GLYPH_W);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int CURSOR_W = 13;
	localparam int ADV_W    = 8;

	localparam logic [12:0] CURSOR_MAX = 13'd4095;
	localparam logic [3:0]  SCALE_MIN  = 4'd1;
	localparam logic [3:0]  SCALE_MAX  = 4'd8;

	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;
	localparam logic [7:0] CHAR_QUERY   = 8'h3F;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ORIGIN  = 2'd0,
		REG_Y_ORIGIN  = 2'd1,
		REG_INK_COLOR = 2'd2,
		REG_SCALE     = 2'd3
	} gbl_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} gbl_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} gbl_cmd_t;

	typedef struct packed {
		logic cur_lit;
		logic rest_empty;
		logic out_free;
	} gbl_sts_t;

	function automatic logic [7:0] fold_code(input logic [7:0] code);
		logic [7:0] c;
		c = code;
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			c = c - CASE_OFFSET;
		end
		if (c[7]) begin
			c = CHAR_QUERY;
		end
		return c;
	endfunction

	// rows top first, leftmost column in the msb of each row
	function automatic logic [MASK_W-1:0] glyph_bits(input logic [7:0] code);
		logic [MASK_W-1:0] g;
		case (code)
			8'h41: g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
			8'h42: g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
			8'h43: g = {5'h0F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h0F};
			8'h44: g = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
			8'h45: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
			8'h46: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
			8'h47: g = {5'h0F,5'h10,5'h10,5'h17,5'h11,5'h11,5'h0F};
			8'h48: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
			8'h49: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F};
			8'h4A: g = {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C};
			8'h4B: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
			8'h4C: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
			8'h4D: g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
			8'h4E: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
			8'h4F: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
			8'h50: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
			8'h51: g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
			8'h52: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
			8'h53: g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
			8'h54: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
			8'h55: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
			8'h56: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
			8'h57: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11};
			8'h58: g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
			8'h59: g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
			8'h5A: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
			8'h30: g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
			8'h31: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
			8'h32: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
			8'h33: g = {5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E};
			8'h34: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
			8'h35: g = {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E};
			8'h36: g = {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E};
			8'h37: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
			8'h38: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
			8'h39: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C};
			8'h3A: g = {5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00};
			8'h2D: g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00};
			8'h2E: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h06};
			8'h2C: g = {5'h00,5'h00,5'h00,5'h00,5'h06,5'h06,5'h08};
			8'h21: g = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04};
			8'h3F: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04};
			8'h3C: g = {5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02};
			8'h3E: g = {5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08};
			8'h2F: g = {5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10};
			8'h2B: g = {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00};
			8'h3D: g = {5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00};
			8'h28: g = {5'h04,5'h08,5'h10,5'h10,5'h10,5'h08,5'h04};
			8'h29: g = {5'h04,5'h02,5'h01,5'h01,5'h01,5'h02,5'h04};
			8'h27: g = {5'h0C,5'h0C,5'h04,5'h00,5'h00,5'h00,5'h00};
			8'h25: g = {5'h19,5'h1A,5'h04,5'h04,5'h04,5'h0B,5'h13};
			8'h2A: g = {5'h00,5'h15,5'h0E,5'h1F,5'h0E,5'h15,5'h00};
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

### rtl/gbl_if.sv
// channel interfaces: characters in, squares out, register writes
interface gbl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       restart;

	modport source (output valid, output char_code, output restart, input ready);
	modport sink (input valid, input char_code, input restart, output ready);
endinterface

interface gbl_sq_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] pixel_x;
	logic signed [12:0] pixel_y;
	logic [3:0]         square_size;
	logic [15:0]        pixel_color;
	logic               last;

	modport source (output valid, output pixel_x, output pixel_y, output square_size,
		output pixel_color, output last, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input square_size,
		input pixel_color, input last, output ready);
endinterface

interface gbl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/gbl_ctrl.sv
// controller state machine: accepts a character and sequences the glyph scan
module gbl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gbl_pkg::gbl_sts_t  sts,
	output gbl_pkg::gbl_cmd_t  cmd
);
	import gbl_pkg::*;

	gbl_state_t state_q;
	gbl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cmd.step && sts.rest_empty) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.step = !sts.cur_lit || sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### rtl/gbl_dp.sv
// datapath: registers, cursor, glyph mask scan and square output register
module gbl_dp (
	input  logic              clk,
	input  logic              arst_n,
	gbl_char_if.sink          chars,
	gbl_cfg_if.sink           cfg,
	gbl_sq_if.source          squares,
	input  gbl_pkg::gbl_cmd_t cmd,
	output gbl_pkg::gbl_sts_t sts
);
	import gbl_pkg::*;

	logic [11:0]          x_origin_q;
	logic [11:0]          y_origin_q;
	logic [15:0]          ink_color_q;
	logic [3:0]           scale_q;
	logic [CURSOR_W-1:0]  cursor_q;

	logic [MASK_W-1:0]    mask_q;
	logic [COL_W-1:0]     col_q;
	logic [CURSOR_W-1:0]  base_q;
	logic signed [13:0]   px_q;
	logic signed [12:0]   py_q;
	logic [3:0]           s_q;
	logic [15:0]          color_q;

	logic                 out_valid_q;
	logic signed [13:0]   out_x_q;
	logic signed [12:0]   out_y_q;
	logic [3:0]           out_size_q;
	logic [15:0]          out_color_q;
	logic                 out_last_q;

	logic [3:0]           s_eff;
	logic [ADV_W-1:0]     adv;
	logic [CURSOR_W-1:0]  base;
	logic signed [13:0]   cursor_sum;
	logic                 emit;

	// clamp of the scale register
	always_comb begin
		if (scale_q < SCALE_MIN) begin
			s_eff = SCALE_MIN;
		end else if (scale_q > SCALE_MAX) begin
			s_eff = SCALE_MAX;
		end else begin
			s_eff = scale_q;
		end
	end

	assign adv        = ADV_W'(ADVANCE) * {4'd0, s_eff};
	assign base       = chars.restart ? {x_origin_q[11], x_origin_q} : cursor_q;
	assign cursor_sum = $signed({base[CURSOR_W-1], base}) + $signed({6'd0, adv});

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q  <= '0;
			y_origin_q  <= '0;
			ink_color_q <= 16'hFFFF;
			scale_q     <= 4'd1;
		end else if (cfg.valid) begin
			unique case (gbl_reg_t'(cfg.index))
				REG_X_ORIGIN:  x_origin_q  <= cfg.data[11:0];
				REG_Y_ORIGIN:  y_origin_q  <= cfg.data[11:0];
				REG_INK_COLOR: ink_color_q <= cfg.data;
				REG_SCALE:     scale_q     <= cfg.data[3:0];
				default:       scale_q     <= scale_q;
			endcase
		end
	end

	// cursor advance with saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (cmd.load) begin
			if (cursor_sum > $signed({1'b0, CURSOR_MAX})) begin
				cursor_q <= CURSOR_MAX;
			end else begin
				cursor_q <= cursor_sum[CURSOR_W-1:0];
			end
		end
	end

	assign sts.cur_lit    = mask_q[MASK_W-1];
	assign sts.rest_empty = (mask_q[MASK_W-2:0] == '0);
	assign sts.out_free   = !out_valid_q || squares.ready;
	assign emit           = cmd.step && sts.cur_lit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			col_q  <= '0;
		end else if (cmd.load) begin
			mask_q <= glyph_bits(fold_code(chars.char_code));
			col_q  <= '0;
		end else if (cmd.step) begin
			mask_q <= {mask_q[MASK_W-2:0], 1'b0};
			if (col_q == COL_W'(GLYPH_W - 1)) begin
				col_q <= '0;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// square position walks with the scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q  <= base;
			px_q    <= $signed({base[CURSOR_W-1], base});
			py_q    <= $signed({y_origin_q[11], y_origin_q});
			s_q     <= s_eff;
			color_q <= ink_color_q;
		end else if (cmd.step) begin
			if (col_q == COL_W'(GLYPH_W - 1)) begin
				px_q <= $signed({base_q[CURSOR_W-1], base_q});
				py_q <= py_q + $signed({9'd0, s_q});
			end else begin
				px_q <= px_q + $signed({10'd0, s_q});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (squares.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q     <= px_q;
			out_y_q     <= py_q;
			out_size_q  <= s_q;
			out_color_q <= color_q;
			out_last_q  <= sts.rest_empty;
		end
	end

	assign squares.valid       = out_valid_q;
	assign squares.pixel_x     = out_x_q;
	assign squares.pixel_y     = out_y_q;
	assign squares.square_size = out_size_q;
	assign squares.pixel_color = out_color_q;
	assign squares.last        = out_last_q;

	a_cursor_sat: assert property (@(posedge clk) disable iff (!arst_n)
		$signed(cursor_q) <= $signed({1'b0, CURSOR_MAX}))
		else $error("cursor above saturation limit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !squares.ready) |-> !emit)
		else $error("pending square overwritten");

	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.rest_empty) |=> (mask_q == '0))
		else $error("mask not empty after final step");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (col_q <= COL_W'(GLYPH_W - 1)))
		else $error("column counter out of range");

endmodule

### rtl/scaled_glyph_blitter_5x7_top.sv
// top level of the scaled 5x7 glyph blitter
// the glyph lookup and cursor advance are registered when a character is accepted, then the glyph cells are scanned
// a character scans up to 35 cells, stopping after the last lit one; a new character is taken only once the scan ends
// a character with no glyph, or the space, scans a single cell; output stalls hold the scan
// reset: asynchronous active low; cursor and origins clear to 0, colour to all ones, scale to 1
module scaled_glyph_blitter_5x7_top (
	input  logic      clk,
	input  logic      arst_n,
	gbl_char_if.sink  chars,
	gbl_cfg_if.sink   cfg,
	gbl_sq_if.source  squares
);
	import gbl_pkg::*;

	gbl_cmd_t cmd;
	gbl_sts_t sts;

	gbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gbl_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.cfg     (cfg),
		.squares (squares),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule
